// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/bclp_pkg.sv
package bclp_pkg;

	localparam int unsigned TS_W       = 32;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0]      CLICK_GAP_RST = 16'd200;
	localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LP_EN  = 3'd0,
		CFG_LP_DUR = 3'd1,
		CFG_LP_PER = 3'd2,
		CFG_RPT_EN = 3'd3,
		CFG_GAP    = 3'd4
	} cfg_idx_t;

	// configuration seen by the step logic
	typedef struct packed {
		logic        long_press_enable;
		logic [15:0] long_press_duration;
		logic [15:0] long_press_period;
		logic        clicks_report_enable;
		logic [15:0] click_gap;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic             active;
		logic             long_press_event;
		logic             clicks_event;
		logic [CNT_W-1:0] click_count;
	} res_t;

endpackage

// File: rtl/bclp_ifs.sv
// sample channel
interface bclp_in_if;
	logic                        valid;
	logic                        ready;
	logic                        level;
	logic [bclp_pkg::TS_W-1:0]   now_ms;

	modport source (output valid, output level, output now_ms, input ready);
	modport sink   (input valid, input level, input now_ms, output ready);
endinterface

// result channel
interface bclp_out_if;
	logic                        valid;
	logic                        ready;
	logic                        active;
	logic                        long_press_event;
	logic                        clicks_event;
	logic [bclp_pkg::CNT_W-1:0]  click_count;

	modport source (output valid, output active, output long_press_event,
		output clicks_event, output click_count, input ready);
	modport sink   (input valid, input active, input long_press_event,
		input clicks_event, input click_count, output ready);
endinterface

// configuration write channel
interface bclp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bclp_pkg::CFG_IDX_W-1:0]   index;
	logic [bclp_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/bclp_cfg_regs.sv
module bclp_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	bclp_cfg_if.sink       cfg_ch,
	output bclp_pkg::cfg_t cfg
);

	bclp_pkg::cfg_t cfg_q;

	// writes are always taken
	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;

	// register file, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_enable    <= 1'b0;
			cfg_q.long_press_duration  <= '0;
			cfg_q.long_press_period    <= '0;
			cfg_q.clicks_report_enable <= 1'b0;
			cfg_q.click_gap            <= bclp_pkg::CLICK_GAP_RST;
		end else if (cfg_ch.valid) begin
			case (bclp_pkg::cfg_idx_t'(cfg_ch.index))
				bclp_pkg::CFG_LP_EN:  cfg_q.long_press_enable    <= cfg_ch.wdata[0];
				bclp_pkg::CFG_LP_DUR: cfg_q.long_press_duration  <= cfg_ch.wdata;
				bclp_pkg::CFG_LP_PER: cfg_q.long_press_period    <= cfg_ch.wdata;
				bclp_pkg::CFG_RPT_EN: cfg_q.clicks_report_enable <= cfg_ch.wdata[0];
				bclp_pkg::CFG_GAP:    cfg_q.click_gap            <= cfg_ch.wdata;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/bclp_step.sv
`include "assert_macros.svh"

module bclp_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      level,
	input  logic [bclp_pkg::TS_W-1:0] now_ms,
	input  bclp_pkg::cfg_t            cfg,
	output bclp_pkg::res_t            res
);

	logic [bclp_pkg::TS_W-1:0]  press_q, release_q;
	logic [bclp_pkg::CNT_W-1:0] clicks_q;
	logic                       held_q;

	logic [bclp_pkg::TS_W-1:0]  press_n, release_n;
	logic [bclp_pkg::CNT_W-1:0] clicks_n;
	logic                       held_n;
	logic [bclp_pkg::TS_W-1:0]  since_press, since_release;
	logic                       pressed, done, gap_over;

	assign pressed     = !level;
	assign since_press = now_ms - press_q;

	// gesture update for the sample in the input register
	always_comb begin
		press_n              = press_q;
		release_n            = release_q;
		clicks_n             = clicks_q;
		held_n               = held_q;
		done                 = 1'b0;
		res.active           = 1'b1;
		res.long_press_event = 1'b0;
		res.clicks_event     = 1'b0;

		if (pressed && press_q == '0) begin
			press_n   = now_ms;
			release_n = '0;
		end else if (pressed && ((press_q != '0 && cfg.long_press_duration != '0 &&
				since_press >= {16'd0, cfg.long_press_duration}) || held_q)) begin
			held_n = 1'b1;
			// repeat event while held
			if (cfg.long_press_enable && since_press >= {16'd0, cfg.long_press_period}) begin
				res.long_press_event = 1'b1;
				press_n              = now_ms;
			end
		end else if (!pressed && press_q != '0) begin
			if (held_q) begin
				res.active = 1'b0;
				done       = 1'b1;
			end else begin
				if (clicks_q != bclp_pkg::CNT_MAX)
					clicks_n = clicks_q + 1'b1;
				release_n = now_ms;
				press_n   = '0;
			end
		end

		// click gap check against the updated release time
		since_release = now_ms - release_n;
		gap_over = !done && release_n != '0 && since_release >= {16'd0, cfg.click_gap};
		if (gap_over) begin
			res.clicks_event = cfg.clicks_report_enable;
			res.active       = 1'b0;
		end

		res.click_count = clicks_n;
	end

	// gesture state, cleared when the gesture ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= '0;
			release_q <= '0;
			clicks_q  <= '0;
			held_q    <= 1'b0;
		end else if (adv) begin
			if (!res.active) begin
				press_q   <= '0;
				release_q <= '0;
				clicks_q  <= '0;
				held_q    <= 1'b0;
			end else begin
				press_q   <= press_n;
				release_q <= release_n;
				clicks_q  <= clicks_n;
				held_q    <= held_n;
			end
		end
	end

	`ASSERT_CLK(a_end_clears, adv && !res.active |=> press_q == '0 && release_q == '0 && clicks_q == '0 && !held_q, "gesture end did not clear state")
	`ASSERT_CLK(a_clicks_grow, adv && res.active |=> clicks_q >= $past(clicks_q), "click count dropped inside a gesture")
	`ASSERT_NEVER(a_lp_needs_hold, res.long_press_event && !held_n, "repeat event without long press")

endmodule

// File: rtl/button_click_long_press_detector.sv
// Button click and long-press detector. Each sample (level, active low, and a
// wrapping millisecond timestamp) gives exactly one result. Samples are taken
// at one per cycle while the input side is not held; a sample's result is
// offered once it has passed from the input register into the result register,
// and the gesture state is updated as the sample moves into the result register
// so the next sample sees it. A full result register that is not taken holds the
// input side after one more sample. Configuration writes are taken at once
// and should only be made while no sample is in flight.
`include "assert_macros.svh"

module button_click_long_press_detector (
	input  logic       clk,
	input  logic       arst_n,
	bclp_in_if.sink    in_ch,
	bclp_out_if.source out_ch,
	bclp_cfg_if.sink   cfg_ch
);

	bclp_pkg::cfg_t cfg;
	bclp_pkg::res_t res, res_s2;

	logic                      valid_s1, valid_s2;
	logic                      level_s1;
	logic [bclp_pkg::TS_W-1:0] now_s1;
	logic                      adv;

	// input register moves on when the result register is free or drained
	assign adv         = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	bclp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	bclp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.level  (level_s1),
		.now_ms (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ch.ready)
				valid_s2 <= 1'b0;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			level_s1 <= in_ch.level;
			now_s1   <= in_ch.now_ms;
		end
		if (adv)
			res_s2 <= res;
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.active           = res_s2.active;
	assign out_ch.long_press_event = res_s2.long_press_event;
	assign out_ch.clicks_event     = res_s2.clicks_event;
	assign out_ch.click_count      = res_s2.click_count;

	`ASSERT_CLK(a_empty_takes, !valid_s1 |-> in_ch.ready, "empty input register refused a sample")
	`ASSERT_CLK(a_stall_holds, valid_s2 && !out_ch.ready |=> valid_s2 && $stable(res_s2), "stalled result changed")
	`ASSERT_NEVER(a_no_overrun, valid_s1 && valid_s2 && !out_ch.ready && in_ch.ready, "sample taken with both stages stuck")

endmodule

// File: test/tb_button_click_long_press_detector.sv
`timescale 1ns / 100ps

module tb_button_click_long_press_detector;

	localparam int CLK_PERIOD  = 12;
	localparam int RESET_CYC   = 9;
	localparam int SETTLE_CYC  = 6;
	localparam int HOLD_CYC    = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int NUM_DIR     = 26;
	localparam int SAT_CLICKS  = 260;

	// index that maps to no register
	localparam logic [bclp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

	// one line of the directed table: a register write or a pin sample
	typedef struct packed {
		logic                            is_reg;
		logic [bclp_pkg::CFG_IDX_W-1:0]  idx;
		logic [bclp_pkg::CFG_DATA_W-1:0] wdata;
		logic                            level;
		logic [bclp_pkg::TS_W-1:0]       now_ms;
		logic                            pinned;
		bclp_pkg::res_t                  want;
	} step_row_t;

	logic clk;
	logic arst_n;

	bclp_in_if  in_ch ();
	bclp_out_if out_ch ();
	bclp_cfg_if cfg_ch ();

	button_click_long_press_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// gesture tracker mirror
	bclp_pkg::cfg_t             cfg_model;
	logic [bclp_pkg::TS_W-1:0]  hold_since;
	logic [bclp_pkg::TS_W-1:0]  lift_since;
	logic [bclp_pkg::CNT_W-1:0] click_tally;
	logic                       long_flag;

	bclp_pkg::res_t gesture_results_due [$];

	int err_cnt;
	int samples_sent;
	int results_seen;
	int reg_writes;
	int repeats_seen;
	int reports_seen;
	int peak_count;
	int snd_idle_pct;
	int rcv_idle_pct;
	bit hold_req;
	bit unsettled;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic step_row_t reg_row(logic [bclp_pkg::CFG_IDX_W-1:0] idx,
			logic [bclp_pkg::CFG_DATA_W-1:0] d);
		reg_row = '{1'b1, idx, d, 1'b1, '0, 1'b0, '0};
	endfunction

	function automatic step_row_t pin_row(logic lvl, logic [bclp_pkg::TS_W-1:0] t);
		pin_row = '{1'b0, '0, '0, lvl, t, 1'b0, '0};
	endfunction

	function automatic step_row_t pin_res(logic lvl, logic [bclp_pkg::TS_W-1:0] t,
			bclp_pkg::res_t w);
		pin_res = '{1'b0, '0, '0, lvl, t, 1'b1, w};
	endfunction

	// directed sequence: reset state, multi-click, wrap, extremes, zero stamps
	step_row_t dir_tab [NUM_DIR] = '{
		pin_res(1'b1, 32'd0,          bclp_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'd0}),
		reg_row(bclp_pkg::CFG_RPT_EN, 16'd1),
		pin_res(1'b0, 32'd0,          bclp_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'd0}),
		pin_row(1'b0, 32'd100),
		pin_row(1'b1, 32'd150),
		pin_row(1'b0, 32'd200),
		pin_row(1'b1, 32'd250),
		pin_row(1'b1, 32'd449),
		pin_res(1'b1, 32'd450,        bclp_pkg::res_t'{1'b0, 1'b0, 1'b1, 8'd2}),
		reg_row(bclp_pkg::CFG_LP_EN, 16'd1),
		reg_row(bclp_pkg::CFG_LP_DUR, 16'hFFFF),
		reg_row(bclp_pkg::CFG_LP_PER, 16'd0),
		pin_row(1'b0, 32'hFFFF_FFF0),
		pin_res(1'b0, 32'h0000_FFEF,  bclp_pkg::res_t'{1'b1, 1'b1, 1'b0, 8'd0}),
		pin_res(1'b1, 32'h0001_0000,  bclp_pkg::res_t'{1'b0, 1'b0, 1'b0, 8'd0}),
		reg_row(bclp_pkg::CFG_LP_DUR, 16'd16),
		pin_row(1'b0, 32'hFFFF_FFF0),
		pin_res(1'b0, 32'd0,          bclp_pkg::res_t'{1'b1, 1'b1, 1'b0, 8'd0}),
		pin_row(1'b0, 32'd3),
		pin_res(1'b1, 32'd4,          bclp_pkg::res_t'{1'b0, 1'b0, 1'b0, 8'd0}),
		reg_row(bclp_pkg::CFG_RPT_EN, 16'd0),
		reg_row(bclp_pkg::CFG_GAP, 16'd0),
		reg_row(CFG_IDX_UNUSED, 16'hFFFF),
		pin_row(1'b0, 32'd10),
		pin_res(1'b1, 32'd10,         bclp_pkg::res_t'{1'b0, 1'b0, 1'b0, 8'd1}),
		pin_res(1'b1, 32'hFFFF_FFFF,  bclp_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'd0})
	};

	// next result of the gesture tracker for one pin sample
	function automatic bclp_pkg::res_t detect_gesture(input logic lvl,
			input logic [bclp_pkg::TS_W-1:0] t);
		bclp_pkg::res_t r;
		logic down;
		logic ended;
		logic [bclp_pkg::TS_W-1:0] held;
		logic [bclp_pkg::TS_W-1:0] quiet;
		down  = !lvl;
		ended = 1'b0;
		held  = t - hold_since;
		r        = '0;
		r.active = 1'b1;
		if (down && hold_since == '0) begin
			hold_since = t;
			lift_since = '0;
		end else if (down && ((hold_since != '0 && cfg_model.long_press_duration != '0 &&
				held >= {16'd0, cfg_model.long_press_duration}) || long_flag)) begin
			long_flag = 1'b1;
			if (cfg_model.long_press_enable && held >= {16'd0, cfg_model.long_press_period}) begin
				r.long_press_event = 1'b1;
				hold_since         = t;
			end
		end else if (!down && hold_since != '0) begin
			if (long_flag) begin
				r.active = 1'b0;
				ended    = 1'b1;
			end else begin
				if (click_tally != bclp_pkg::CNT_MAX)
					click_tally = click_tally + 1'b1;
				lift_since = t;
				hold_since = '0;
			end
		end
		// gap after the last release closes the gesture
		quiet = t - lift_since;
		if (!ended && lift_since != '0 && quiet >= {16'd0, cfg_model.click_gap}) begin
			r.clicks_event = cfg_model.clicks_report_enable;
			r.active       = 1'b0;
		end
		r.click_count = click_tally;
		if (!r.active) begin
			hold_since  = '0;
			lift_since  = '0;
			click_tally = '0;
			long_flag   = 1'b0;
		end
		return r;
	endfunction

	// let every sample in flight come out before touching registers
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (gesture_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		unsettled = 1'b0;
	endtask

	task automatic write_reg(input logic [bclp_pkg::CFG_IDX_W-1:0] idx,
			input logic [bclp_pkg::CFG_DATA_W-1:0] d);
		if (unsettled)
			settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		reg_writes++;
		case (idx)
			bclp_pkg::CFG_LP_EN:  cfg_model.long_press_enable    = d[0];
			bclp_pkg::CFG_LP_DUR: cfg_model.long_press_duration  = d;
			bclp_pkg::CFG_LP_PER: cfg_model.long_press_period    = d;
			bclp_pkg::CFG_RPT_EN: cfg_model.clicks_report_enable = d[0];
			bclp_pkg::CFG_GAP:    cfg_model.click_gap            = d;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic lp_en, input logic [15:0] dur, input logic [15:0] per,
			input logic rpt, input logic [15:0] gap);
		write_reg(bclp_pkg::CFG_LP_EN, {15'd0, lp_en});
		write_reg(bclp_pkg::CFG_LP_DUR, dur);
		write_reg(bclp_pkg::CFG_LP_PER, per);
		write_reg(bclp_pkg::CFG_RPT_EN, {15'd0, rpt});
		write_reg(bclp_pkg::CFG_GAP, gap);
	endtask

	// offer one sample and queue what it should produce
	task automatic send_sample(input logic lvl, input logic [bclp_pkg::TS_W-1:0] t,
			input logic pinned = 1'b0, input bclp_pkg::res_t pinned_res = '0);
		bclp_pkg::res_t r;
		cfg_ch.valid <= 1'b0;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.level  <= lvl;
		in_ch.now_ms <= t;
		do @(posedge clk); while (!in_ch.ready);
		r = detect_gesture(lvl, t);
		gesture_results_due.push_back(pinned ? pinned_res : r);
		samples_sent++;
		unsettled = 1'b1;
	endtask

	// press and release runs with random timing scaled to the current setting
	task automatic run_gestures(input int n_items);
		int left;
		int run_len;
		int span;
		int scale;
		logic lvl;
		logic [bclp_pkg::TS_W-1:0] t;
		scale = 4;
		if (int'(cfg_model.long_press_duration) > scale)
			scale = int'(cfg_model.long_press_duration);
		if (int'(cfg_model.long_press_period) > scale)
			scale = int'(cfg_model.long_press_period);
		if (int'(cfg_model.click_gap) > scale)
			scale = int'(cfg_model.click_gap);
		left = n_items;
		lvl  = 1'b1;
		if ($urandom_range(3) == 0)
			t = 32'hFFFF_FFFF - $urandom_range(4 * scale);
		else
			t = $urandom;
		while (left > 0) begin
			if ($urandom_range(99) < 8) begin
				// noise: any level at any time
				send_sample(1'($urandom_range(1)), $urandom);
				left--;
			end else begin
				if ($urandom_range(19) == 0)
					t = $urandom;
				lvl     = ~lvl;
				run_len = int'($urandom_range(1, 6));
				span    = int'($urandom_range(1, scale / 2 + 1));
				repeat (run_len) begin
					t = t + $urandom_range(0, span);
					send_sample(lvl, t);
					left--;
				end
			end
		end
	endtask

	// result side: check each transfer, then pick the next ready
	initial begin
		int hold_left;
		bclp_pkg::res_t got;
		bclp_pkg::res_t want;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.active, out_ch.long_press_event, out_ch.clicks_event,
					out_ch.click_count};
				results_seen++;
				if (got.long_press_event) repeats_seen++;
				if (got.clicks_event) reports_seen++;
				if (int'(got.click_count) > peak_count) peak_count = int'(got.click_count);
				if (gesture_results_due.size() == 0) begin
					$error("result transfer with nothing expected");
					err_cnt++;
				end else begin
					want = gesture_results_due.pop_front();
					if (got.active !== want.active) begin
						$error("active: expected %0d, got %0d", want.active, got.active);
						err_cnt++;
					end
					if (got.long_press_event !== want.long_press_event) begin
						$error("long_press_event: expected %0d, got %0d",
							want.long_press_event, got.long_press_event);
						err_cnt++;
					end
					if (got.clicks_event !== want.clicks_event) begin
						$error("clicks_event: expected %0d, got %0d",
							want.clicks_event, got.clicks_event);
						err_cnt++;
					end
					if (got.click_count !== want.click_count) begin
						$error("click_count: expected %0d, got %0d",
							want.click_count, got.click_count);
						err_cnt++;
					end
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYC;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet_cyc;
		quiet_cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet_cyc);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [bclp_pkg::TS_W-1:0] t;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.level  = 1'b1;
		in_ch.now_ms = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		err_cnt      = 0;
		samples_sent = 0;
		results_seen = 0;
		reg_writes   = 0;
		repeats_seen = 0;
		reports_seen = 0;
		peak_count   = 0;
		hold_req     = 1'b0;
		unsettled    = 1'b0;
		cfg_model    = '{1'b0, 16'd0, 16'd0, 1'b0, bclp_pkg::CLICK_GAP_RST};
		hold_since   = '0;
		lift_since   = '0;
		click_tally  = '0;
		long_flag    = 1'b0;

		// sender idles lightly, receiver heavily
		snd_idle_pct = 18;
		rcv_idle_pct = 67;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_reg)
				write_reg(dir_tab[i].idx, dir_tab[i].wdata);
			else
				send_sample(dir_tab[i].level, dir_tab[i].now_ms, dir_tab[i].pinned,
					dir_tab[i].want);
		end

		// random gestures over several settings
		set_config(1'b1, 16'd40, 16'd15, 1'b1, 16'd30);
		run_gestures(300);
		set_config(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		run_gestures(200);

		// now the receiver idles lightly, sender heavily
		snd_idle_pct = 67;
		rcv_idle_pct = 18;
		set_config(1'b0, 16'd25, 16'd0, 1'b1, 16'd0);
		run_gestures(250);
		set_config(1'b1, 16'd0, 16'd10, 1'b1, 16'd50);
		run_gestures(250);

		// no idling from here on
		snd_idle_pct = 0;
		rcv_idle_pct = 0;

		// click count saturation: fast clicks inside a wide gap, then let it lapse
		set_config(1'b0, 16'd0, 16'd0, 1'b1, 16'hFFFF);
		t = $urandom_range(1, 32'hFFFF_0000);
		repeat (SAT_CLICKS) begin
			send_sample(1'b0, t);
			send_sample(1'b1, t + 32'd1);
			t = t + 32'd2;
		end
		send_sample(1'b1, t + 32'd65535);

		// long receiver hold-off while samples keep coming
		set_config(1'b1, 16'd100, 16'd30, 1'b0, 16'd120);
		hold_req = 1'b1;
		run_gestures(150);

		settle();
		$display("ran %0d samples and %0d register writes, %0d results checked",
			samples_sent, reg_writes, results_seen);
		$display("saw %0d long-press repeats, %0d click reports, click count up to %0d",
			repeats_seen, reports_seen, peak_count);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
